/* src/lbp_pkg.sv */
// ----------------------------------------------------------------------------
// lbp_pkg - shared types and constants of the LED blink pattern player
// Symbol codes, playback phases, word layouts and register defaults.
// ----------------------------------------------------------------------------
package lbp_pkg;

  // pattern symbol codes
  localparam logic [1:0] SYM_NONE = 2'd0;
  localparam logic [1:0] SYM_DOT  = 2'd1;
  localparam logic [1:0] SYM_DASH = 2'd2;
  localparam logic [1:0] SYM_SYNC = 2'd3;

  // input command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_SHORT = 2'd0;
  localparam logic [1:0] CFG_LONG  = 2'd1;
  localparam logic [1:0] CFG_GAP   = 2'd2;
  localparam logic [1:0] CFG_SYNC  = 2'd3;

  // register reset values, in ticks
  localparam logic [15:0] SHORT_RST = 16'd100;
  localparam logic [15:0] LONG_RST  = 16'd300;
  localparam logic [15:0] GAP_RST   = 16'd200;
  localparam logic [15:0] SYNC_RST  = 16'd1000;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ON   = 2'd1,
    PH_GAP  = 2'd2,
    PH_LOAD = 2'd3
  } phase_t;

  typedef struct packed {
    logic       command;
    logic [1:0] symbol;
    logic       last_symbol;
    logic       repeat_req;
    logic [7:0] duty;
  } in_word_t;

  typedef struct packed {
    logic [7:0] led_level;
    logic       playing;
    logic       pattern_overflow;
  } out_word_t;

  // a zero duration counts as one tick
  function automatic logic [15:0] at_least_one(input logic [15:0] v);
    return (v == 16'd0) ? 16'd1 : v;
  endfunction

  // on time of a symbol
  function automatic logic [15:0] on_ticks(input logic [1:0]  sym,
                                           input logic [15:0] short_v,
                                           input logic [15:0] long_v,
                                           input logic [15:0] sync_v);
    logic [15:0] v;
    case (sym)
      SYM_DASH: v = long_v;
      SYM_SYNC: v = sync_v;
      default:  v = short_v;
    endcase
    return at_least_one(v);
  endfunction

endpackage

/* src/lbp_ram.sv */
// ----------------------------------------------------------------------------
// lbp_ram - generic simple dual port RAM
// One write port, one read port, read data registered (old data on collision).
// ----------------------------------------------------------------------------
module lbp_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* src/led_blink_pattern_player_unit.sv */
// ----------------------------------------------------------------------------
// led_blink_pattern_player_unit - LED blink pattern player
// Stores a pattern of dot, dash and sync symbols and plays it on tick words.
// ----------------------------------------------------------------------------
// Each input word is either a load (one pattern symbol) or a one-millisecond
// tick, and every accepted word yields exactly one output word showing the
// LED level, the playing flag and the overflow flag after that word. The
// block takes one word per clock cycle; an input word is stalled only while
// the two-entry output buffer (output register plus skid register) is full.
// A load outside pattern assembly aborts playback and starts a new pattern;
// the load flagged last sets its repeat mode and duty and starts playback of a non-empty pattern.
// Symbols live in a MAX_SYMBOLS x 2 pattern RAM with a registered
// read. The RAM is read every cycle at the index that follows the current
// play position, so the next symbol is already on hand when a phase ends;
// a write that lands on the address being read is forwarded, and the first
// symbol of the pattern is kept in a register for the start of playback.
// Stored entries need no clearing: only entries written for the current
// pattern are ever read. Configuration registers (short, long, gap and sync
// times in ticks) are written through the cfg port, which is always ready;
// a zero time counts as one tick.
// ----------------------------------------------------------------------------
module led_blink_pattern_player_unit #(
  parameter int MAX_SYMBOLS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  // input words
  input  logic              in_valid,
  output logic              in_stall,
  input  lbp_pkg::in_word_t in_data,
  // output words
  output logic              out_valid,
  input  logic              out_stall,
  output lbp_pkg::out_word_t out_data,
  // configuration writes
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data
);

  localparam int AW = $clog2(MAX_SYMBOLS);
  localparam int LW = $clog2(MAX_SYMBOLS + 1);

  // configuration registers
  logic [15:0] short_r, long_r, gap_r, sync_r;

  // playback state
  lbp_pkg::phase_t phase_r, phase_nxt;
  logic [15:0]     ticks_r, ticks_nxt;
  logic [AW-1:0]   idx_r, idx_nxt;
  logic [LW-1:0]   len_r, len_nxt;
  logic            rep_r, rep_nxt;
  logic [7:0]      bright_r, bright_nxt;
  logic            ovf_r, ovf_nxt;
  logic [1:0]      cur_sym_r, cur_sym_nxt;
  logic [1:0]      first_sym_r, first_sym_nxt;

  // pattern RAM access and forwarding
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  logic [1:0]    ram_rdata;
  logic          fwd_hit_r;
  logic [1:0]    fwd_sym_r;
  logic [1:0]    next_sym;

  // output buffer
  logic               out_valid_r, skid_valid_r;
  lbp_pkg::out_word_t out_word_r, skid_word_r, new_word;
  logic               in_acc, out_take;

  // helpers
  logic [LW-1:0] base_len;
  logic [LW-1:0] idx_inc;
  logic [LW-1:0] succ_inc;
  logic          start_new;
  logic [1:0]    start_sym;

  assign in_acc   = in_valid && !in_stall;
  assign out_take = out_valid_r && !out_stall;
  assign in_stall = skid_valid_r;
  assign cfg_ready = 1'b1;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_r <= lbp_pkg::SHORT_RST;
      long_r  <= lbp_pkg::LONG_RST;
      gap_r   <= lbp_pkg::GAP_RST;
      sync_r  <= lbp_pkg::SYNC_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lbp_pkg::CFG_SHORT: short_r <= cfg_data;
        lbp_pkg::CFG_LONG:  long_r  <= cfg_data;
        lbp_pkg::CFG_GAP:   gap_r   <= cfg_data;
        lbp_pkg::CFG_SYNC:  sync_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // pattern RAM; the symbol after the play position comes from the registered
  // read of its address, with a same-cycle write forwarded over the old data
  // --------------------------------------------------------------------------
  lbp_ram #(
    .WIDTH (2),
    .DEPTH (MAX_SYMBOLS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_data.symbol),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign next_sym = fwd_hit_r ? fwd_sym_r : ram_rdata;

  // successor of the next play index, wrapping to the pattern start
  assign succ_inc  = LW'(idx_nxt) + LW'(1);
  assign ram_raddr = (succ_inc >= len_nxt) ? '0 : succ_inc[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else begin
      fwd_hit_r <= ram_we && (ram_waddr == ram_raddr);
    end
    fwd_sym_r <= in_data.symbol;
  end

  // --------------------------------------------------------------------------
  // next state of the player
  // --------------------------------------------------------------------------
  assign base_len  = (phase_r == lbp_pkg::PH_LOAD) ? len_r : '0;
  assign idx_inc   = LW'(idx_r) + LW'(1);
  assign start_new = (phase_r != lbp_pkg::PH_LOAD);
  assign ram_waddr = base_len[AW-1:0];

  always_comb begin
    phase_nxt     = phase_r;
    ticks_nxt     = ticks_r;
    idx_nxt       = idx_r;
    len_nxt       = len_r;
    rep_nxt       = rep_r;
    bright_nxt    = bright_r;
    ovf_nxt       = ovf_r;
    cur_sym_nxt   = cur_sym_r;
    first_sym_nxt = first_sym_r;
    ram_we        = 1'b0;
    start_sym     = first_sym_r;

    if (in_acc) begin
      if (in_data.command == lbp_pkg::CMD_LOAD) begin
        // open a new pattern unless one is being assembled
        phase_nxt = lbp_pkg::PH_LOAD;
        ticks_nxt = '0;
        idx_nxt   = '0;
        len_nxt   = base_len;
        ovf_nxt   = start_new ? 1'b0 : ovf_r;
        if (in_data.symbol != lbp_pkg::SYM_NONE) begin
          if (base_len < LW'(MAX_SYMBOLS)) begin
            ram_we  = 1'b1;
            len_nxt = base_len + LW'(1);
            if (base_len == '0) begin
              first_sym_nxt = in_data.symbol;
            end
          end else begin
            ovf_nxt = 1'b1;
          end
        end
        start_sym = first_sym_nxt;
        if (in_data.last_symbol) begin
          rep_nxt    = in_data.repeat_req;
          bright_nxt = in_data.duty;
          if (len_nxt == '0) begin
            phase_nxt = lbp_pkg::PH_IDLE;
          end else begin
            phase_nxt   = lbp_pkg::PH_ON;
            cur_sym_nxt = start_sym;
            ticks_nxt   = lbp_pkg::on_ticks(start_sym, short_r, long_r, sync_r);
          end
        end
      end else if (phase_r == lbp_pkg::PH_ON || phase_r == lbp_pkg::PH_GAP) begin
        if (ticks_r > 16'd1) begin
          ticks_nxt = ticks_r - 16'd1;
        end else if (phase_r == lbp_pkg::PH_ON && cur_sym_r != lbp_pkg::SYM_SYNC) begin
          phase_nxt = lbp_pkg::PH_GAP;
          ticks_nxt = lbp_pkg::at_least_one(gap_r);
        end else if (idx_inc >= len_r && !rep_r) begin
          // end of a single pass
          phase_nxt = lbp_pkg::PH_IDLE;
          ticks_nxt = '0;
        end else begin
          // advance to the prefetched symbol
          idx_nxt     = (idx_inc >= len_r) ? '0 : idx_inc[AW-1:0];
          phase_nxt   = lbp_pkg::PH_ON;
          cur_sym_nxt = next_sym;
          ticks_nxt   = lbp_pkg::on_ticks(next_sym, short_r, long_r, sync_r);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= lbp_pkg::PH_IDLE;
      ticks_r     <= '0;
      idx_r       <= '0;
      len_r       <= '0;
      rep_r       <= 1'b0;
      bright_r    <= '0;
      ovf_r       <= 1'b0;
      cur_sym_r   <= lbp_pkg::SYM_NONE;
      first_sym_r <= lbp_pkg::SYM_NONE;
    end else begin
      phase_r     <= phase_nxt;
      ticks_r     <= ticks_nxt;
      idx_r       <= idx_nxt;
      len_r       <= len_nxt;
      rep_r       <= rep_nxt;
      bright_r    <= bright_nxt;
      ovf_r       <= ovf_nxt;
      cur_sym_r   <= cur_sym_nxt;
      first_sym_r <= first_sym_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // output word and two-entry output buffer
  // --------------------------------------------------------------------------
  always_comb begin
    new_word.led_level        = (phase_nxt == lbp_pkg::PH_ON) ? bright_nxt : 8'd0;
    new_word.playing          = (phase_nxt == lbp_pkg::PH_ON) ||
                                (phase_nxt == lbp_pkg::PH_GAP);
    new_word.pattern_overflow = ovf_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (in_acc) begin
      // skid is empty here: fill the output register or park in skid
      if (!out_valid_r || out_take) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_r  <= skid_valid_r;
      skid_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (!out_valid_r || out_take) begin
        out_word_r <= new_word;
      end else begin
        skid_word_r <= new_word;
      end
    end else if (out_take && skid_valid_r) begin
      out_word_r <= skid_word_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds a word while output register is empty");

  a_play_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == lbp_pkg::PH_ON || phase_r == lbp_pkg::PH_GAP) |->
      (len_r != '0 && LW'(idx_r) < len_r))
    else $error("playback position outside the stored pattern");

  a_ticks_live: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == lbp_pkg::PH_ON || phase_r == lbp_pkg::PH_GAP) |-> ticks_r != 16'd0)
    else $error("active phase with no ticks left");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> len_r == LW'(MAX_SYMBOLS))
    else $error("overflow flagged while pattern store not full");

  a_no_write_in_play: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (in_acc && in_data.command == lbp_pkg::CMD_LOAD))
    else $error("pattern write without an accepted load word");

endmodule
